FILE: rtl/core/command_line_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// Command line tokenizer: assertion macros
// Shared property forms for the concurrent checks of the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CLTK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CLTK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cltk_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Character codes, quote and status codes, queue entry type, escape decode.
// ----------------------------------------------------------------------------
`default_nettype none

package cltk_pkg;

	localparam int LINE_BYTES = 128;
	// Lines longer than this many bytes are reported as too long.
	localparam logic [7:0] LEN_LIMIT = 8'(LINE_BYTES - 4);

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [6:0] ARG_LIMIT_RST = 7'd16;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_ESC       = 8'h1B;

	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_SINGLE = 2'd1;
	localparam logic [1:0] QM_DOUBLE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_UNCLOSED = 2'd3;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic       eol;
		logic [7:0] oc;
		logic [1:0] status;
	} cltk_entry_t;

	function automatic logic [7:0] decode_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h6E:   r = 8'h0A; // n
			8'h72:   r = 8'h0D; // r
			8'h74:   r = 8'h09; // t
			8'h62:   r = 8'h08; // b
			8'h66:   r = 8'h0C; // f
			8'h65:   r = CH_ESC; // e
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/command_line_tokenizer_core.sv
// Path: an accepted byte is written into the entry queue, then popped into the output register.
// Throughput: one byte per cycle while the entry queue has room (in_ready high).
// The entry queue lets the front keep taking bytes while a result waits.
// Bytes that open an escape or open or close a quote give no result.
// Reset (arst_n low, asynchronous): line state cleared, arg_limit set to 16.
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Splits a byte stream into compacted, tagged tokens with an end-of-line summary.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_line_tokenizer_core_defines.svh"

module command_line_tokenizer_core
	import cltk_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [7:0]      out_char,
	output logic            token_start,
	output logic [5:0]      token_index,
	output logic [5:0]      arg_count,
	output logic [1:0]      status
);

	logic [6:0]  arg_limit_q;
	logic [5:0]  cap;
	logic        push, pop, q_full, q_valid;
	cltk_entry_t wr_entry, rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_limit_q <= ARG_LIMIT_RST;
		end else if (cfg_write) begin
			arg_limit_q <= cfg_data;
		end
	end

	// at least one token, at most 63
	always_comb begin
		if (arg_limit_q < 7'd2) begin
			cap = 6'd1;
		end else if (arg_limit_q > 7'd64) begin
			cap = 6'd63;
		end else begin
			cap = 6'(arg_limit_q - 7'd1);
		end
	end

	cltk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	cltk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.full      (q_full),
		.not_empty (q_valid)
	);

	cltk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (rd_entry),
		.pop         (pop),
		.cap         (cap),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.out_char    (out_char),
		.token_start (token_start),
		.token_index (token_index),
		.arg_count   (arg_count),
		.status      (status)
	);

	`CLTK_ASSERT_NOW(a_summary_clean, out_valid && kind == KIND_SUMMARY, out_char == CH_NUL && !token_start && token_index == 6'd0, "summary beat carries character fields")
	`CLTK_ASSERT_NOW(a_bad_status_no_count, out_valid && kind == KIND_SUMMARY && status != ST_OK, arg_count == 6'd0, "failed line reports a token count")
	`CLTK_ASSERT_NOW(a_index_below_cap, out_valid && kind == KIND_CHAR && token_start, token_index < cap && out_char != CH_NUL, "token start beyond limit or on separator")
	`CLTK_ASSERT_NEXT(a_pop_fills_output, pop, out_valid, "popped entry did not reach output")

endmodule

`default_nettype wire

FILE: rtl/core/cltk_front.sv
// ----------------------------------------------------------------------------
// Command line tokenizer: front end
// Accepts bytes, tracks escape, quote and line length, and pushes one
// classified entry for every byte that produces a result.
// ----------------------------------------------------------------------------
`default_nettype none

module cltk_front
	import cltk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        q_full,
	output logic             push,
	output cltk_entry_t      entry
);

	logic       esc_q, esc_d;
	logic [1:0] quote_q, quote_d;
	logic [7:0] len_q, len_d;
	logic       accept;
	logic [7:0] closer;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign closer   = (quote_q == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

	always_comb begin
		push    = 1'b0;
		entry   = '0;
		esc_d   = esc_q;
		quote_d = quote_q;
		len_d   = len_q;
		if (accept) begin
			if (ch == CH_NUL) begin
				push      = 1'b1;
				entry.eol = 1'b1;
				if (len_q == 8'd0) begin
					entry.status = ST_EMPTY;
				end else if (len_q > LEN_LIMIT) begin
					entry.status = ST_TOO_LONG;
				end else if (quote_q != QM_NONE) begin
					entry.status = ST_UNCLOSED;
				end else begin
					entry.status = ST_OK;
				end
				// drop any pending escape and start a fresh line
				esc_d   = 1'b0;
				quote_d = QM_NONE;
				len_d   = 8'd0;
			end else begin
				if (len_q != 8'hFF) begin
					len_d = len_q + 8'd1;
				end
				if (esc_q) begin
					esc_d    = 1'b0;
					push     = 1'b1;
					entry.oc = decode_escape(ch);
				end else if (ch == CH_BACKSLASH && quote_q != QM_SINGLE) begin
					esc_d = 1'b1;
				end else if (quote_q != QM_NONE) begin
					if (ch == closer) begin
						quote_d = QM_NONE;
					end else begin
						push     = 1'b1;
						entry.oc = ch;
					end
				end else if (ch == CH_SQUOTE) begin
					quote_d = QM_SINGLE;
				end else if (ch == CH_DQUOTE) begin
					quote_d = QM_DOUBLE;
				end else if (ch == CH_SPACE) begin
					push     = 1'b1;
					entry.oc = CH_NUL;
				end else begin
					push     = 1'b1;
					entry.oc = ch;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			quote_q <= QM_NONE;
			len_q   <= 8'd0;
		end else begin
			esc_q   <= esc_d;
			quote_q <= quote_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/cltk_queue.sv
// ----------------------------------------------------------------------------
// Command line tokenizer: entry queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cltk_queue
	import cltk_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire cltk_entry_t wr_entry,
	input  wire logic        pop,
	output cltk_entry_t      rd_entry,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cltk_entry_t   slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/cltk_back.sv
// ----------------------------------------------------------------------------
// Command line tokenizer: back end
// Pops classified entries, counts tokens, and fills the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cltk_back
	import cltk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire cltk_entry_t q_entry,
	output logic             pop,
	input  wire logic [5:0]  cap,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [7:0]       out_char,
	output logic             token_start,
	output logic [5:0]       token_index,
	output logic [5:0]       arg_count,
	output logic [1:0]       status
);

	logic       valid_q;
	logic       prev_sep_q;
	logic [5:0] tokens_q;
	logic       kind_q, start_q;
	logic [7:0] char_q;
	logic [5:0] index_q, count_q;
	logic [1:0] status_q;
	logic       is_sep, start;

	// advance when the output register is free or its beat is taken now
	assign pop    = q_valid && (!valid_q || out_ready);
	assign is_sep = (q_entry.oc == CH_NUL);
	assign start  = !q_entry.eol && prev_sep_q && !is_sep && (tokens_q < cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			prev_sep_q <= 1'b1;
			tokens_q   <= 6'd0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				if (q_entry.eol) begin
					prev_sep_q <= 1'b1;
					tokens_q   <= 6'd0;
				end else begin
					prev_sep_q <= is_sep;
					if (start) begin
						tokens_q <= tokens_q + 6'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_entry.eol ? KIND_SUMMARY : KIND_CHAR;
			char_q   <= q_entry.eol ? CH_NUL : q_entry.oc;
			start_q  <= start;
			index_q  <= start ? tokens_q : 6'd0;
			count_q  <= (q_entry.eol && q_entry.status == ST_OK) ? tokens_q : 6'd0;
			status_q <= q_entry.eol ? q_entry.status : ST_OK;
		end
	end

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign out_char    = char_q;
	assign token_start = start_q;
	assign token_index = index_q;
	assign arg_count   = count_q;
	assign status      = status_q;

endmodule

`default_nettype wire
